@@ design/vn_pkg.sv @@
package vn_pkg;

    localparam int COMP_W      = 16;
    localparam int MAG_W       = 20;
    localparam int RAD_W       = 40;   // (x^2+y^2+z^2) * 256
    localparam int REM_W       = MAG_W + 2;
    localparam int SQRT_STEPS  = 20;   // one root bit per stage
    localparam int DIV_STEPS   = 15;   // one quotient bit per stage
    localparam int NUM_W       = 34;   // |c| << 18
    localparam int COMP_SHIFT  = 18;
    localparam int LANES       = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [DIV_STEPS-1:0] UNIT_ONE = 15'd16384;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
        logic [MAG_W-1:0]         mag;
        logic                     zero;
    } item_t;

endpackage

@@ design/vn_front.sv @@
module vn_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [vn_pkg::COMP_W-1:0]     comp_x,
    input  logic signed [vn_pkg::COMP_W-1:0]     comp_y,
    input  logic signed [vn_pkg::COMP_W-1:0]     comp_z,
    input  logic [vn_pkg::MAG_W-1:0]             min_mag,
    input  logic                                 q_full,
    output logic                                 push,
    output vn_pkg::item_t                        push_item
);

    localparam int N = vn_pkg::SQRT_STEPS;

    logic adv;

    // square stage
    logic        sq_valid_reg;
    logic [30:0] sqx_reg, sqy_reg, sqz_reg;
    logic signed [vn_pkg::COMP_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [31:0] px, py, pz;

    // root stages: index 0 holds the radicand, index N the finished root
    logic                             st_valid_reg [0:N];
    logic [vn_pkg::RAD_W-1:0]         rad_reg      [0:N];
    logic [vn_pkg::REM_W-1:0]         rem_reg      [0:N];
    logic [vn_pkg::MAG_W-1:0]         root_reg     [0:N];
    logic signed [vn_pkg::COMP_W-1:0] sx_reg       [0:N];
    logic signed [vn_pkg::COMP_W-1:0] sy_reg       [0:N];
    logic signed [vn_pkg::COMP_W-1:0] sz_reg       [0:N];

    logic [vn_pkg::RAD_W-1:0]  rad_next  [0:N-1];
    logic [vn_pkg::REM_W-1:0]  rem_next  [0:N-1];
    logic [vn_pkg::MAG_W-1:0]  root_next [0:N-1];
    logic [vn_pkg::REM_W+1:0]  tr        [0:N-1];
    logic [vn_pkg::REM_W+1:0]  trial     [0:N-1];
    logic [31:0]               sum;

    assign adv      = !q_full;
    assign in_stall = q_full;

    assign px  = 32'(comp_x) * 32'(comp_x);
    assign py  = 32'(comp_y) * 32'(comp_y);
    assign pz  = 32'(comp_z) * 32'(comp_z);
    assign sum = 32'(sqx_reg) + 32'(sqy_reg) + 32'(sqz_reg);

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            tr[k]    = {rem_reg[k], rad_reg[k][vn_pkg::RAD_W-1 -: 2]};
            trial[k] = {2'b00, root_reg[k], 2'b01};
            rad_next[k] = rad_reg[k] << 2;
            if (tr[k] >= trial[k])
            begin
                rem_next[k]  = vn_pkg::REM_W'(tr[k] - trial[k]);
                root_next[k] = {root_reg[k][vn_pkg::MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = vn_pkg::REM_W'(tr[k]);
                root_next[k] = {root_reg[k][vn_pkg::MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            for (int k = 0; k <= N; k++)
                st_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg    <= in_valid;
            st_valid_reg[0] <= sq_valid_reg;
            for (int k = 0; k < N; k++)
                st_valid_reg[k+1] <= st_valid_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg <= px[30:0];
            sqy_reg <= py[30:0];
            sqz_reg <= pz[30:0];
            cx_reg  <= comp_x;
            cy_reg  <= comp_y;
            cz_reg  <= comp_z;

            rad_reg[0]  <= {sum, 8'h00};
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            sx_reg[0]   <= cx_reg;
            sy_reg[0]   <= cy_reg;
            sz_reg[0]   <= cz_reg;
            for (int k = 0; k < N; k++)
            begin
                rad_reg[k+1]  <= rad_next[k];
                rem_reg[k+1]  <= rem_next[k];
                root_reg[k+1] <= root_next[k];
                sx_reg[k+1]   <= sx_reg[k];
                sy_reg[k+1]   <= sy_reg[k];
                sz_reg[k+1]   <= sz_reg[k];
            end
        end
    end

    // classify: zero length always counts as below the minimum
    assign push           = adv && st_valid_reg[N];
    assign push_item.x    = sx_reg[N];
    assign push_item.y    = sy_reg[N];
    assign push_item.z    = sz_reg[N];
    assign push_item.mag  = root_reg[N];
    assign push_item.zero = (root_reg[N] == '0) || (root_reg[N] < min_mag);

endmodule

@@ design/vn_queue.sv @@
module vn_queue #(
    parameter int DEPTH = vn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vn_pkg::item_t push_item,
    input  logic          pop,
    output vn_pkg::item_t head_item,
    output logic          full,
    output logic          nonempty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    vn_pkg::item_t mem [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign nonempty  = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && nonempty;
    assign head_item = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ design/vn_back.sv @@
module vn_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  vn_pkg::item_t                    q_item,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [vn_pkg::COMP_W-1:0] unit_x,
    output logic signed [vn_pkg::COMP_W-1:0] unit_y,
    output logic signed [vn_pkg::COMP_W-1:0] unit_z,
    output logic [vn_pkg::MAG_W-1:0]         magnitude,
    output logic                             is_zero
);

    localparam int D  = vn_pkg::DIV_STEPS;
    localparam int L  = vn_pkg::LANES;
    localparam int QW = vn_pkg::DIV_STEPS;
    localparam int NW = vn_pkg::NUM_W;

    logic en;

    logic                     b_valid_reg [0:D];
    logic [vn_pkg::MAG_W-1:0] mag_reg     [0:D];
    logic                     zero_reg    [0:D];
    logic                     neg_reg     [0:D][0:L-1];
    logic [NW-1:0]            r_reg       [0:D][0:L-1];
    logic [QW-1:0]            q_reg       [0:D][0:L-1];

    logic signed [vn_pkg::COMP_W-1:0] lane_in [0:L-1];
    logic [vn_pkg::COMP_W-1:0]        abs_in  [0:L-1];
    logic [NW:0]                      dvs     [0:D-1];
    logic                             geq     [0:D-1][0:L-1];
    logic [NW-1:0]                    r_next  [0:D-1][0:L-1];
    logic [QW-1:0]                    qs      [0:L-1];
    logic signed [vn_pkg::COMP_W-1:0] unit_v  [0:L-1];

    logic                             out_valid_reg;
    logic signed [vn_pkg::COMP_W-1:0] ux_reg, uy_reg, uz_reg;
    logic [vn_pkg::MAG_W-1:0]         mag_out_reg;
    logic                             zero_out_reg;

    assign en  = !(out_valid_reg && out_stall);
    assign pop = en && q_valid;

    assign lane_in[0] = q_item.x;
    assign lane_in[1] = q_item.y;
    assign lane_in[2] = q_item.z;

    always_comb
    begin
        for (int l = 0; l < L; l++)
            abs_in[l] = lane_in[l][vn_pkg::COMP_W-1] ? 16'(-lane_in[l]) : 16'(lane_in[l]);
    end

    // restoring division, quotient bit D-1-j decided in stage j
    always_comb
    begin
        for (int j = 0; j < D; j++)
        begin
            dvs[j] = (NW+1)'(mag_reg[j]) << (D - 1 - j);
            for (int l = 0; l < L; l++)
            begin
                geq[j][l]    = ({1'b0, r_reg[j][l]} >= dvs[j]);
                r_next[j][l] = geq[j][l] ? NW'({1'b0, r_reg[j][l]} - dvs[j]) : r_reg[j][l];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            qs[l]     = (q_reg[D][l] > vn_pkg::UNIT_ONE) ? vn_pkg::UNIT_ONE : q_reg[D][l];
            unit_v[l] = neg_reg[D][l] ? -16'(qs[l]) : 16'(qs[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int j = 0; j <= D; j++)
                b_valid_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg[0] <= q_valid;
            for (int j = 0; j < D; j++)
                b_valid_reg[j+1] <= b_valid_reg[j];
            out_valid_reg <= b_valid_reg[D];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0]  <= q_item.mag;
            zero_reg[0] <= q_item.zero;
            for (int l = 0; l < L; l++)
            begin
                neg_reg[0][l] <= lane_in[l][vn_pkg::COMP_W-1];
                r_reg[0][l]   <= NW'(abs_in[l]) << vn_pkg::COMP_SHIFT;
                q_reg[0][l]   <= '0;
            end
            for (int j = 0; j < D; j++)
            begin
                mag_reg[j+1]  <= mag_reg[j];
                zero_reg[j+1] <= zero_reg[j];
                for (int l = 0; l < L; l++)
                begin
                    neg_reg[j+1][l] <= neg_reg[j][l];
                    r_reg[j+1][l]   <= r_next[j][l];
                    q_reg[j+1][l]   <= {q_reg[j][l][QW-2:0], geq[j][l]};
                end
            end
            ux_reg       <= zero_reg[D] ? '0 : unit_v[0];
            uy_reg       <= zero_reg[D] ? '0 : unit_v[1];
            uz_reg       <= zero_reg[D] ? '0 : unit_v[2];
            mag_out_reg  <= zero_reg[D] ? '0 : mag_reg[D];
            zero_out_reg <= zero_reg[D];
        end
    end

    assign out_valid = out_valid_reg;
    assign unit_x    = ux_reg;
    assign unit_y    = uy_reg;
    assign unit_z    = uz_reg;
    assign magnitude = mag_out_reg;
    assign is_zero   = zero_out_reg;

endmodule

@@ design/vector3_normalizer_unit.sv @@
// 3D vector normalizer: signed Q8.8 vector in, Q1.14 unit vector plus magnitude out.
// Input channel: in_valid / in_stall with comp_x, comp_y, comp_z; one transfer
//   per accepted vector.
// Output channel: out_valid / out_stall with unit_x, unit_y, unit_z, magnitude
//   (1/16 LSB units) and is_zero; exactly one transfer per input transfer, in order.
// Config: cfg_we / cfg_wdata write min_magnitude; change it only while idle.
// Throughput: one vector per cycle, sustained while neither in_stall nor out_stall is high.
// Path from input transfer to out_valid: squares registered at the transfer,
//   the sum register, 20 root stages, the queue write and read, 15 divider
//   stages, output register.
// The front (squares, root, classify) stalls the input only when the queue
//   between front and back is full; the back drains the queue as long as the
//   output register can take data.
// Holding out_stall while out_valid is high freezes the back and output register;
//   the front keeps taking input until the queue fills, then raises in_stall.
// Reset empties all stages and the queue and sets min_magnitude to 1.
module vector3_normalizer_unit #(
    parameter int QUEUE_DEPTH = vn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [vn_pkg::COMP_W-1:0] comp_x,
    input  logic signed [vn_pkg::COMP_W-1:0] comp_y,
    input  logic signed [vn_pkg::COMP_W-1:0] comp_z,
    input  logic                             cfg_we,
    input  logic [vn_pkg::MAG_W-1:0]         cfg_wdata,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [vn_pkg::COMP_W-1:0] unit_x,
    output logic signed [vn_pkg::COMP_W-1:0] unit_y,
    output logic signed [vn_pkg::COMP_W-1:0] unit_z,
    output logic [vn_pkg::MAG_W-1:0]         magnitude,
    output logic                             is_zero
);

    logic [vn_pkg::MAG_W-1:0] min_mag_reg;

    logic          push, pop, q_full, q_nonempty;
    vn_pkg::item_t push_item, head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_mag_reg <= vn_pkg::MAG_W'(1);
        else if (cfg_we)
            min_mag_reg <= cfg_wdata;
    end

    // front: squares, sum, pipelined integer root, below-minimum check
    vn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .comp_x    (comp_x),
        .comp_y    (comp_y),
        .comp_z    (comp_z),
        .min_mag   (min_mag_reg),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    vn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (q_full),
        .nonempty  (q_nonempty)
    );

    // back: three divider lanes, saturation, sign, output register
    vn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_nonempty),
        .q_item    (head_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .unit_x    (unit_x),
        .unit_y    (unit_y),
        .unit_z    (unit_z),
        .magnitude (magnitude),
        .is_zero   (is_zero)
    );

endmodule
